@@ hdl/tsched_pkg.sv @@
// Package for the task scheduler: widths, policy codes, controller states and
// the command/status structs between controller and datapath. No dependencies.
package tsched_pkg;

    localparam int MaxTasks  = 16;
    localparam int IdW       = $clog2(MaxTasks);
    localparam int CntW      = $clog2(MaxTasks + 1);
    localparam int BurstW    = 24;
    localparam int QuantW    = 16;
    localparam int ModeW     = 2;
    localparam logic [QuantW-1:0] ResetQuantum = 16'd500;

    typedef enum logic [ModeW-1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_PSJF = 2'd3
    } policy_t;

    localparam logic CfgIdxPolicy  = 1'b0;
    localparam logic CfgIdxQuantum = 1'b1;

    localparam logic OpTick    = 1'b0;
    localparam logic OpArrival = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_POP,
        ST_SCAN,
        ST_COMMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input item
        logic update;    // apply arrival or tick
        logic pop_step;  // examine one ring entry
        logic scan_init; // reset the slot scan
        logic scan_step; // examine one slot
        logic commit;    // apply the decision
        logic out_load;  // fill the output register
    } cmd_t;

    typedef struct packed {
        logic pop_needed;  // ring pop is the first choice
        logic pop_done;    // ring pop finished (found or empty)
        logic scan_needed; // a slot scan is needed
        logic scan_last;   // scan on its last slot
    } sts_t;

endpackage

@@ hdl/task_scheduler_fifo_rr_sjf_psjf.sv @@
// Top level of the task scheduler: controller plus datapath.
// Depends on tsched_pkg, tsched_ctrl, tsched_dp and tsched_ram.
//
// One item (a tick or a task arrival) is taken at a time and yields one result:
// the task running afterwards, a task retired on a tick, and a reject flag.
// The item passes through the update, ring-pop, slot-scan, commit and output
// states in that order. A slot scan (preemptive SJF, SJF with no running task,
// or a FIFO/round-robin restart that finds no live ring entry) walks all 16
// slots; the slot-scan walker visits one slot per cycle. Each ring entry popped
// costs a pop plus a read turnaround, and a restart may drain a full ring of
// stale entries before a scan. A new item is taken in the idle cycle after the
// previous result sits in the output register; the output register holds a
// result until it is taken.
module task_scheduler_fifo_rr_sjf_psjf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_idx,
    input  logic [tsched_pkg::QuantW-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [3:0]                        task_id,
    input  logic [tsched_pkg::BurstW-1:0]     burst_length,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              run_valid,
    output logic [3:0]                        run_task,
    output logic                              done_valid,
    output logic [3:0]                        done_task,
    output logic                              status
);

    tsched_pkg::cmd_t cmd;
    tsched_pkg::sts_t sts;
    logic busy;

    // hold the input side while an item is in work
    assign in_stall = busy;

    tsched_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsched_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .op          (op),
        .task_id     (task_id),
        .burst_length(burst_length),
        .out_stall   (out_stall),
        .busy        (busy),
        .out_valid   (out_valid),
        .run_valid   (run_valid),
        .run_task    (run_task),
        .done_valid  (done_valid),
        .done_task   (done_task),
        .status      (status)
    );

endmodule

@@ hdl/tsched_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tsched_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/tsched_ctrl.sv @@
// Controller state machine of the task scheduler.
// Depends on tsched_pkg.
module tsched_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  tsched_pkg::sts_t   sts,
    output tsched_pkg::cmd_t   cmd
);

    tsched_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsched_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsched_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = tsched_pkg::ST_UPDATE;
                end
            end
            tsched_pkg::ST_UPDATE:
            begin
                state_next = tsched_pkg::ST_POP;
            end
            tsched_pkg::ST_POP:
            begin
                if (!sts.pop_needed || sts.pop_done)
                begin
                    state_next = tsched_pkg::ST_SCAN;
                end
            end
            tsched_pkg::ST_SCAN:
            begin
                if (!sts.scan_needed || sts.scan_last)
                begin
                    state_next = tsched_pkg::ST_COMMIT;
                end
            end
            tsched_pkg::ST_COMMIT:
            begin
                state_next = tsched_pkg::ST_OUT;
            end
            tsched_pkg::ST_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = tsched_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsched_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tsched_pkg::ST_IDLE:
            begin
                cmd.load = in_valid && !in_stall;
            end
            tsched_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            tsched_pkg::ST_POP:
            begin
                cmd.pop_step = sts.pop_needed && !sts.pop_done;
                cmd.scan_init = !sts.pop_needed || sts.pop_done;
            end
            tsched_pkg::ST_SCAN:
            begin
                cmd.scan_step = sts.scan_needed;
            end
            tsched_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            tsched_pkg::ST_OUT:
            begin
                cmd.out_load = !out_valid || !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.update, cmd.pop_step, cmd.scan_step, cmd.commit,
                    cmd.out_load}) <= 1)
        else $error("more than one controller command");
    a_update_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.update)
        else $error("update did not follow load");
    a_commit_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == tsched_pkg::ST_OUT)
        else $error("commit not followed by output state");
`endif

endmodule

@@ hdl/tsched_dp.sv @@
// Datapath of the task scheduler: slot table, ready ring, running task,
// slot scan and output register. Depends on tsched_pkg and tsched_ram.
module tsched_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsched_pkg::cmd_t                  cmd,
    output tsched_pkg::sts_t                  sts,
    input  logic                              cfg_we,
    input  logic                              cfg_idx,
    input  logic [tsched_pkg::QuantW-1:0]     cfg_data,
    input  logic                              op,
    input  logic [3:0]                        task_id,
    input  logic [tsched_pkg::BurstW-1:0]     burst_length,
    input  logic                              out_stall,
    output logic                              busy,
    output logic                              out_valid,
    output logic                              run_valid,
    output logic [3:0]                        run_task,
    output logic                              done_valid,
    output logic [3:0]                        done_task,
    output logic                              status
);

    localparam int IdW = tsched_pkg::IdW;
    localparam int CntW = tsched_pkg::CntW;
    localparam int BW = tsched_pkg::BurstW;
    localparam int QW = tsched_pkg::QuantW;
    localparam int NT = tsched_pkg::MaxTasks;

    // configuration
    tsched_pkg::policy_t mode_reg;
    logic [QW-1:0] quantum_reg;

    // captured item
    logic op_reg;
    logic [3:0] id_reg;
    logic [BW-1:0] burst_reg;

    // scheduler state
    logic [BW-1:0] rem_reg [NT];
    logic [NT-1:0] active_reg;
    logic [IdW-1:0] head_reg;
    logic [CntW-1:0] count_reg;
    logic [IdW-1:0] cur_reg;
    logic cur_valid_reg;
    logic [QW-1:0] slice_reg;
    logic done_v_reg;
    logic [IdW-1:0] done_t_reg;
    logic status_reg;

    // decision
    logic pop_needed_reg, pop_done_reg, pop_found_reg;
    logic [IdW-1:0] pop_id_reg;
    logic pop_rd_pending_reg;
    logic scan_needed_reg;
    logic [CntW-1:0] scan_idx_reg;
    logic scan_found_reg;
    logic [IdW-1:0] scan_best_reg;
    logic [BW-1:0] scan_best_rem_reg;
    logic scan_with_cur_reg, scan_shortest_reg;
    logic rotate_reg;

    logic ring_we;
    logic [IdW-1:0] ring_waddr, ring_wdata;
    logic [IdW-1:0] ring_rdata;

    tsched_ram #(.Width(IdW), .Depth(NT)) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(head_reg),
        .rdata(ring_rdata)
    );

    logic [QW-1:0] q_eff;
    assign q_eff = (quantum_reg == '0) ? QW'(1) : quantum_reg;

    logic mode_queue;
    assign mode_queue = (mode_reg == tsched_pkg::POL_FIFO) || (mode_reg == tsched_pkg::POL_RR);

    logic id_ok;
    assign id_ok = ({1'b0, id_reg} < 5'(NT)) && !active_reg[id_reg[IdW-1:0]];

    logic [IdW-1:0] scan_slot;
    assign scan_slot = scan_idx_reg[IdW-1:0];

    logic scan_cand;
    assign scan_cand = active_reg[scan_slot]
        && (scan_with_cur_reg || !(cur_valid_reg && scan_slot == cur_reg));

    logic ring_hit;
    assign ring_hit = active_reg[ring_rdata] && !(cur_valid_reg && ring_rdata == cur_reg);

    logic [BW-1:0] cur_rem;
    assign cur_rem = rem_reg[cur_reg];

    always_comb
    begin
        sts.pop_needed = pop_needed_reg;
        sts.pop_done = pop_done_reg;
        sts.scan_needed = scan_needed_reg;
        sts.scan_last = (scan_idx_reg == CntW'(NT - 1));
    end

    // ring write: arrival push at update, rotation push at commit
    always_comb
    begin
        ring_we = 1'b0;
        ring_waddr = head_reg + count_reg[IdW-1:0];
        ring_wdata = id_reg[IdW-1:0];
        if (cmd.update && op_reg == tsched_pkg::OpArrival && id_ok && mode_queue
            && count_reg < CntW'(NT))
        begin
            ring_we = 1'b1;
        end
        else if (cmd.commit && rotate_reg && pop_found_reg && count_reg < CntW'(NT))
        begin
            ring_we = 1'b1;
            ring_wdata = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tsched_pkg::POL_FIFO;
            quantum_reg <= tsched_pkg::ResetQuantum;
            active_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            cur_reg <= '0;
            cur_valid_reg <= 1'b0;
            slice_reg <= '0;
            busy <= 1'b0;
            out_valid <= 1'b0;
            pop_needed_reg <= 1'b0;
            pop_done_reg <= 1'b0;
            pop_found_reg <= 1'b0;
            pop_id_reg <= '0;
            pop_rd_pending_reg <= 1'b0;
            scan_needed_reg <= 1'b0;
            scan_idx_reg <= '0;
            scan_found_reg <= 1'b0;
            scan_best_reg <= '0;
            scan_best_rem_reg <= '0;
            scan_with_cur_reg <= 1'b0;
            scan_shortest_reg <= 1'b0;
            rotate_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == tsched_pkg::CfgIdxPolicy)
                begin
                    mode_reg <= tsched_pkg::policy_t'(cfg_data[tsched_pkg::ModeW-1:0]);
                end
                else
                begin
                    quantum_reg <= cfg_data;
                end
            end

            if (cmd.load)
            begin
                busy <= 1'b1;
            end

            if (cmd.update)
            begin
                // pop decision needs the post-update state; set up next cycle
                if (op_reg == tsched_pkg::OpArrival)
                begin
                    if (id_ok)
                    begin
                        active_reg[id_reg[IdW-1:0]] <= 1'b1;
                        if (mode_queue && count_reg < CntW'(NT))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                else if (cur_valid_reg)
                begin
                    if (slice_reg != '1)
                    begin
                        slice_reg <= slice_reg + 1'b1;
                    end
                    if (cur_rem <= BW'(1))
                    begin
                        active_reg[cur_reg] <= 1'b0;
                        cur_valid_reg <= 1'b0;
                    end
                end
                pop_done_reg <= 1'b0;
                pop_found_reg <= 1'b0;
                pop_rd_pending_reg <= 1'b1;
                pop_needed_reg <= 1'b1; // refined on the first pop cycle
            end

            if (cmd.pop_step)
            begin
                if (pop_rd_pending_reg)
                begin
                    // first pop cycle: decide whether a pop is wanted at all
                    pop_rd_pending_reg <= 1'b0;
                    rotate_reg <= cur_valid_reg;
                    if (!(mode_queue && (!cur_valid_reg
                        || (mode_reg == tsched_pkg::POL_RR && slice_reg >= q_eff))))
                    begin
                        pop_needed_reg <= 1'b0;
                    end
                    else if (count_reg == '0)
                    begin
                        pop_done_reg <= 1'b1;
                    end
                end
                else if (count_reg == '0)
                begin
                    pop_done_reg <= 1'b1;
                end
                else
                begin
                    head_reg <= head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                    pop_rd_pending_reg <= 1'b1;
                    if (ring_hit)
                    begin
                        pop_found_reg <= 1'b1;
                        pop_id_reg <= ring_rdata;
                        pop_done_reg <= 1'b1;
                    end
                end
            end

            if (cmd.scan_init)
            begin
                scan_found_reg <= 1'b0;
                scan_idx_reg <= '0;
                case (mode_reg)
                    tsched_pkg::POL_FIFO, tsched_pkg::POL_RR:
                    begin
                        scan_needed_reg <= !cur_valid_reg && !pop_found_reg;
                        scan_with_cur_reg <= 1'b0;
                        scan_shortest_reg <= 1'b0;
                    end
                    tsched_pkg::POL_SJF:
                    begin
                        scan_needed_reg <= !cur_valid_reg;
                        scan_with_cur_reg <= 1'b0;
                        scan_shortest_reg <= 1'b1;
                    end
                    default:
                    begin
                        scan_needed_reg <= 1'b1;
                        scan_with_cur_reg <= 1'b1;
                        scan_shortest_reg <= 1'b1;
                    end
                endcase
            end

            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_cand && (!scan_found_reg
                    || (scan_shortest_reg && rem_reg[scan_slot] < scan_best_rem_reg)))
                begin
                    scan_found_reg <= 1'b1;
                    scan_best_reg <= scan_slot;
                    scan_best_rem_reg <= rem_reg[scan_slot];
                end
            end

            if (cmd.commit)
            begin
                if (pop_found_reg)
                begin
                    if (rotate_reg && count_reg < CntW'(NT))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    cur_reg <= pop_id_reg;
                    cur_valid_reg <= 1'b1;
                    slice_reg <= '0;
                end
                else if (scan_needed_reg && scan_found_reg
                    && !(cur_valid_reg && scan_best_reg == cur_reg))
                begin
                    cur_reg <= scan_best_reg;
                    cur_valid_reg <= 1'b1;
                    slice_reg <= '0;
                end
                scan_needed_reg <= 1'b0;
                pop_needed_reg <= 1'b0;
            end

            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
                busy <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            id_reg <= task_id;
            burst_reg <= burst_length;
            done_v_reg <= 1'b0;
            done_t_reg <= '0;
            status_reg <= 1'b0;
        end
        if (cmd.update)
        begin
            if (op_reg == tsched_pkg::OpArrival)
            begin
                if (id_ok)
                begin
                    rem_reg[id_reg[IdW-1:0]] <= burst_reg;
                end
                else
                begin
                    status_reg <= 1'b1;
                end
            end
            else if (cur_valid_reg)
            begin
                if (cur_rem != '0)
                begin
                    rem_reg[cur_reg] <= cur_rem - 1'b1;
                end
                if (cur_rem <= BW'(1))
                begin
                    done_v_reg <= 1'b1;
                    done_t_reg <= cur_reg;
                end
            end
        end
        if (cmd.out_load)
        begin
            run_valid <= cur_valid_reg;
            run_task <= cur_valid_reg ? 4'(cur_reg) : 4'd0;
            done_valid <= done_v_reg;
            done_task <= 4'(done_t_reg);
            status <= status_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(NT))
        else $error("ring count above depth");
    a_run_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!cur_valid_reg || active_reg[cur_reg]))
        else $error("running task not active");
    a_done_not_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_valid && run_valid) |-> run_task != done_task)
        else $error("retired task reported running");
`endif

endmodule

@@ dv/tb_task_scheduler_fifo_rr_sjf_psjf.sv @@
// Self-checking testbench for task_scheduler_fifo_rr_sjf_psjf.
// Depends on tsched_pkg and the scheduler RTL; a built-in scheduler model predicts each result.
module tb_task_scheduler_fifo_rr_sjf_psjf;

    timeunit 1ns;
    timeprecision 1ps;

    // Result of one item: the running task, the retired task, the reject flag.
    typedef struct packed {
        logic       run_valid;
        logic [3:0] run_task;
        logic       done_valid;
        logic [3:0] done_task;
        logic       status;
    } sched_result_t;

    // One row of the directed stimulus table.
    typedef struct {
        logic          op;
        logic [3:0]    id;
        logic [23:0]   burst;
        bit            has_fixed;
        sched_result_t fixed;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_idx;
    logic [tsched_pkg::QuantW-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          op;
    logic [3:0]                    task_id;
    logic [tsched_pkg::BurstW-1:0] burst_length;
    logic                          out_valid;
    logic                          out_stall;
    logic                          run_valid;
    logic [3:0]                    run_task;
    logic                          done_valid;
    logic [3:0]                    done_task;
    logic                          status;

    task_scheduler_fifo_rr_sjf_psjf u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .task_id      (task_id),
        .burst_length (burst_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .run_valid    (run_valid),
        .run_task     (run_task),
        .done_valid   (done_valid),
        .done_task    (done_task),
        .status       (status)
    );

    // Scheduler model state, kept at the block's widths.
    logic [23:0]          mdl_remain [tsched_pkg::MaxTasks];
    logic                 mdl_active [tsched_pkg::MaxTasks];
    logic [3:0]           mdl_ring   [tsched_pkg::MaxTasks];
    logic [3:0]           mdl_head;
    logic [4:0]           mdl_count;
    logic [3:0]           mdl_cur;
    logic                 mdl_cur_v;
    logic [15:0]          mdl_slice;
    tsched_pkg::policy_t  mdl_policy;
    logic [15:0]          mdl_quantum;

    sched_result_t expected_results [$];
    int            mismatches;
    int            hold_off_cycles;   // one long receiver hold-off, in cycles

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fixed time limit: far beyond the slowest correct run.
    initial
    begin
        #60ms;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void model_reset();
        for (int i = 0; i < tsched_pkg::MaxTasks; i++)
        begin
            mdl_remain[i] = '0;
            mdl_active[i] = 1'b0;
            mdl_ring[i]   = '0;
        end
        mdl_head    = '0;
        mdl_count   = '0;
        mdl_cur     = '0;
        mdl_cur_v   = 1'b0;
        mdl_slice   = '0;
        mdl_policy  = tsched_pkg::POL_FIFO;
        mdl_quantum = tsched_pkg::ResetQuantum;
    endfunction

    function automatic void ring_enqueue(logic [3:0] id);
        if (mdl_count < tsched_pkg::MaxTasks)
        begin
            mdl_ring[4'(mdl_head + mdl_count[3:0])] = id;
            mdl_count++;
        end
    endfunction

    // Pop until an active task that is not already running turns up.
    function automatic bit ring_dequeue(output logic [3:0] id);
        logic [3:0] t;
        id = '0;
        while (mdl_count > 0)
        begin
            t = mdl_ring[mdl_head];
            mdl_head++;
            mdl_count--;
            if (mdl_active[t] && !(mdl_cur_v && t == mdl_cur))
            begin
                id = t;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit lowest_idle(output logic [3:0] id);
        id = '0;
        for (int i = 0; i < tsched_pkg::MaxTasks; i++)
            if (mdl_active[i] && !(mdl_cur_v && 4'(i) == mdl_cur))
            begin
                id = 4'(i);
                return 1'b1;
            end
        return 1'b0;
    endfunction

    // Least remaining time; strict compare keeps the lower slot on a tie.
    function automatic bit least_remaining(bit with_cur, output logic [3:0] id);
        bit found;
        found = 1'b0;
        id = '0;
        for (int i = 0; i < tsched_pkg::MaxTasks; i++)
        begin
            if (!mdl_active[i])
                continue;
            if (!with_cur && mdl_cur_v && 4'(i) == mdl_cur)
                continue;
            if (!found || mdl_remain[i] < mdl_remain[id])
            begin
                id = 4'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void dispatch(logic [3:0] id);
        mdl_cur   = id;
        mdl_cur_v = 1'b1;
        mdl_slice = '0;
    endfunction

    function automatic void pick_next();
        logic [3:0]  n;
        logic [16:0] q;
        q = (mdl_quantum == 0) ? 17'd1 : {1'b0, mdl_quantum};
        case (mdl_policy)
            tsched_pkg::POL_FIFO, tsched_pkg::POL_RR:
            begin
                if (!mdl_cur_v)
                begin
                    if (ring_dequeue(n) || lowest_idle(n))
                        dispatch(n);
                end
                else if (mdl_policy == tsched_pkg::POL_RR && {1'b0, mdl_slice} >= q)
                begin
                    if (ring_dequeue(n))
                    begin
                        ring_enqueue(mdl_cur);
                        dispatch(n);
                    end
                end
            end
            tsched_pkg::POL_SJF:
                if (!mdl_cur_v && least_remaining(1'b0, n))
                    dispatch(n);
            default:
                if (least_remaining(1'b1, n) && !(mdl_cur_v && n == mdl_cur))
                    dispatch(n);
        endcase
    endfunction

    function automatic sched_result_t schedule_item(logic o, logic [3:0] id, logic [23:0] b);
        sched_result_t r;
        r = '0;
        if (o == tsched_pkg::OpArrival)
        begin
            if (mdl_active[id])
                r.status = 1'b1;
            else
            begin
                mdl_active[id] = 1'b1;
                mdl_remain[id] = b;
                if (mdl_policy == tsched_pkg::POL_FIFO || mdl_policy == tsched_pkg::POL_RR)
                    ring_enqueue(id);
            end
        end
        else if (mdl_cur_v)
        begin
            if (mdl_remain[mdl_cur] != 0)
                mdl_remain[mdl_cur]--;
            if (mdl_slice != 16'hFFFF)
                mdl_slice++;
            if (mdl_remain[mdl_cur] == 0)
            begin
                mdl_active[mdl_cur] = 1'b0;
                mdl_cur_v    = 1'b0;
                r.done_valid = 1'b1;
                r.done_task  = mdl_cur;
            end
        end
        pick_next();
        r.run_valid = mdl_cur_v;
        r.run_task  = mdl_cur_v ? mdl_cur : 4'd0;
        return r;
    endfunction

    // ------------------------------------------------------------- driving

    // Offer one item after a random gap; hold it until accepted. Valid stays
    // high after the accepting edge until the next call or an idle phase drops it.
    task automatic send_item(logic o, logic [3:0] id, logic [23:0] b, bit has_fixed,
                             sched_result_t fixed);
        sched_result_t r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        task_id      <= id;
        burst_length <= b;
        r = schedule_item(o, id, b);
        // Directed rows with a typed-in answer cross-check the model too.
        if (has_fixed && r != fixed)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: table %h model %h", fixed, r);
        end
        expected_results.push_back(has_fixed ? fixed : r);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(logic idx, logic [tsched_pkg::QuantW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == tsched_pkg::CfgIdxPolicy)
            mdl_policy = tsched_pkg::policy_t'(val[1:0]);
        else
            mdl_quantum = val;
    endtask

    // Drain, then let the block's own work settle before a config write.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Random workload: arrivals, mostly onto free slots, mixed with ticks.
    task automatic random_phase(int n);
        logic [3:0]  id;
        logic [23:0] b;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            id   = 4'($urandom);
            case ($urandom_range(0, 9))
                0:       b = 24'hFFFFFF ^ 24'($urandom_range(0, 255));
                1:       b = 24'($urandom);
                2:       b = 24'd0;
                default: b = 24'($urandom_range(1, 12));
            endcase
            if (pick < 35)
            begin
                // Prefer a free slot; a duplicate now and then.
                if (pick < 30)
                    for (int t = 0; t < tsched_pkg::MaxTasks && mdl_active[id]; t++)
                        id++;
                send_item(tsched_pkg::OpArrival, id, b, 1'b0, '0);
            end
            else
                send_item(tsched_pkg::OpTick, id, b, 1'b0, '0);
        end
    endtask

    // -------------------------------------------------------------- checking

    // Receiver: random stall per item, with one long hold-off to fill the block.
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {run_valid, run_task, done_valid, done_task, status};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: run %b/%0d done %b/%0d status %b, ",
                                  "expected run %b/%0d done %b/%0d status %b"},
                                 got.run_valid, got.run_task, got.done_valid,
                                 got.done_task, got.status, want.run_valid,
                                 want.run_task, want.done_valid, want.done_task,
                                 want.status);
                end
            end
        end
    end

    // ------------------------------------------------------------- sequence

    dir_row_t dir_table [$];

    function automatic dir_row_t row(logic o, logic [3:0] id, logic [23:0] b, bit hf,
                                     sched_result_t f);
        dir_row_t d;
        d.op = o;
        d.id = id;
        d.burst = b;
        d.has_fixed = hf;
        d.fixed = f;
        return d;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = 1'b0;
        task_id      = '0;
        burst_length = '0;
        mismatches   = 0;
        hold_off_cycles = 0;
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under FIFO after reset: tick while idle, max/zero bursts,
        // occupied slot rejects, lowest and highest slot ids.
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0,  24'd0,      1, '0));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd15, 24'hFFFFFF, 1,
                                {1'b1, 4'd15, 1'b0, 4'd0, 1'b0}));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd15, 24'd1,      1,
                                {1'b1, 4'd15, 1'b0, 4'd0, 1'b1}));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd0,  24'd0,      1,
                                {1'b1, 4'd15, 1'b0, 4'd0, 1'b0}));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd5,  24'd2,      0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd15, 24'hFFFFFF, 0, '0));
        foreach (dir_table[i])
            send_item(dir_table[i].op, dir_table[i].id, dir_table[i].burst,
                      dir_table[i].has_fixed, dir_table[i].fixed);

        // Switch to preemptive SJF: zero burst retires at once, preemption.
        wait_idle();
        write_reg(tsched_pkg::CfgIdxPolicy, tsched_pkg::QuantW'(tsched_pkg::POL_PSJF));
        dir_table.delete();
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd3, 24'd0, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0, 24'd0, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd7, 24'd3, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd6, 24'd3, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0, 24'd0, 0, '0));
        foreach (dir_table[i])
            send_item(dir_table[i].op, dir_table[i].id, dir_table[i].burst,
                      dir_table[i].has_fixed, dir_table[i].fixed);

        // Round robin, zero quantum (acts as one); a task left over from the earlier
        // phases keeps running, and the ring rotation skips stale entries.
        wait_idle();
        write_reg(tsched_pkg::CfgIdxPolicy, tsched_pkg::QuantW'(tsched_pkg::POL_RR));
        write_reg(tsched_pkg::CfgIdxQuantum, 16'd0);
        dir_table.delete();
        dir_table.push_back(row(tsched_pkg::OpArrival, 4'd1, 24'd2, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0, 24'd0, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0, 24'd0, 0, '0));
        dir_table.push_back(row(tsched_pkg::OpTick,    4'd0, 24'd0, 0, '0));
        foreach (dir_table[i])
            send_item(dir_table[i].op, dir_table[i].id, dir_table[i].burst,
                      dir_table[i].has_fixed, dir_table[i].fixed);

        // Random phases through every policy and several quanta, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            write_reg(tsched_pkg::CfgIdxPolicy, tsched_pkg::QuantW'(ph % 4));
            case (ph)
                1:       write_reg(tsched_pkg::CfgIdxQuantum, 16'hFFFF);
                5:       write_reg(tsched_pkg::CfgIdxQuantum, 16'd1);
                default: write_reg(tsched_pkg::CfgIdxQuantum, 16'($urandom_range(1, 4)));
            endcase
            // Long receiver hold-off while items keep coming, once.
            if (ph == 2)
                hold_off_cycles = 400;
            random_phase(85);
        end

        in_valid <= 1'b0;
        fork
            begin
                while (expected_results.size() != 0)
                    @(posedge clk);
                repeat (50) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                mismatches++;
            end
        join_any
        disable fork;
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tsched_pkg.sv
hdl/tsched_ram.sv
hdl/tsched_ctrl.sv
hdl/tsched_dp.sv
hdl/task_scheduler_fifo_rr_sjf_psjf.sv
dv/tb_task_scheduler_fifo_rr_sjf_psjf.sv
